### sv/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants
// Widths, the sequencer state type and the per-cell control word for the
// insertion sorter.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int MAX_LEN    = 32;   // cells in the chain, 2..64
  localparam int DATA_WIDTH = 32;   // value width, 8..64
  localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

  typedef logic signed [DATA_WIDTH-1:0] value_t;

  typedef enum logic {
    ST_LOAD,   // taking values into the chain
    ST_EMIT    // draining the chain, smallest first
  } sis_state_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic   load;     // insert value into the chain
    logic   unload;   // shift the chain one place toward cell 0
    value_t value;    // value being inserted
  } cell_ctrl_t;

endpackage

### sv/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell: one slot of the sorting chain
// Holds one value and its valid bit. On load it keeps its value, takes the
// new value, or takes its left neighbor's value; on unload it takes its
// right neighbor's value.
// ----------------------------------------------------------------------------
module sis_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sis_pkg::cell_ctrl_t ctrl,
  input  sis_pkg::value_t     left_data,
  input  logic                left_valid,
  input  logic                left_ins,    // left cell makes room too
  input  sis_pkg::value_t     right_data,
  input  logic                right_valid,
  output sis_pkg::value_t     data,
  output logic                valid,
  output logic                ins          // new value belongs here or left
);
  import sis_pkg::*;

  value_t data_r, data_nxt;
  logic   valid_r, valid_nxt;

  // empty slot or a strictly greater value: equal values stay ahead (stable)
  assign ins = !valid_r || (data_r > ctrl.value);

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.unload) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctrl.load && ins) begin
      if (left_ins) begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end else begin
        data_nxt  = ctrl.value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

### sv/segment_insertion_sorter.sv
// ----------------------------------------------------------------------------
// segment_insertion_sorter: streaming insertion sorter for one run of values
// A chain of compare cells keeps the run sorted ascending; the last word
// triggers a drain of the chain, smallest value first.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed value per word, in_tlast on the final value of a run.
//   out_* : the run in ascending order (stable for equal values), one word
//           per cycle while out_tready is high; out_tlast on the largest, final
//           word; out_tuser set on every word of a run that had more than
//           MAX_LEN values (the extra values are discarded).
// Throughput: one input word per cycle while loading; every cell compares
//   against the broadcast value and shifts in the same cycle. Draining a run
//   of N stored values shifts the chain one place per accepted output word;
//   in_tready is low during the drain.
// Latency: the first sorted word is valid the cycle after the last input
//   word is accepted.
// Reset (rst_n low, synchronous): all cells empty, overflow flag cleared,
//   block in load mode. Cell data is not reset; no empty cell is ever output.
// Stall: while out_tready is low the chain holds and out_tdata stays put,
//   since the output word is cell 0's register itself.
// ----------------------------------------------------------------------------
module segment_insertion_sorter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sis_pkg::TDATA_W-1:0] in_tdata,    // [DATA_WIDTH-1:0] value
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sis_pkg::TDATA_W-1:0] out_tdata,   // [DATA_WIDTH-1:0] sorted_value
  output logic                        out_tlast,
  output logic                        out_tuser    // [0] dropped
);
  import sis_pkg::*;

  sis_state_t state_r, state_nxt;
  logic       ovf_r, ovf_nxt;

  cell_ctrl_t ctrl;
  value_t     cell_data  [MAX_LEN];
  logic [MAX_LEN-1:0] cell_valid;
  logic [MAX_LEN-1:0] cell_ins;

  logic in_acc;
  logic out_acc;
  logic full;
  logic run_done;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = cell_valid[MAX_LEN-1];

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_acc    = out_tvalid && out_tready;
  // final word: nothing behind cell 0
  assign out_tlast  = !cell_valid[1];
  assign run_done   = out_acc && out_tlast;

  assign ctrl.load   = in_acc && !full;
  assign ctrl.unload = out_acc;
  assign ctrl.value  = in_tdata[DATA_WIDTH-1:0];

  // ---- cell chain: cell 0 holds the smallest value ----
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    value_t lft_data, rgt_data;
    logic   lft_valid, lft_ins, rgt_valid;

    if (i == 0) begin : g_head
      assign lft_data  = '0;
      assign lft_valid = 1'b0;
      assign lft_ins   = 1'b0;   // first slot needing room takes the new value
    end else begin : g_body
      assign lft_data  = cell_data[i-1];
      assign lft_valid = cell_valid[i-1];
      assign lft_ins   = cell_ins[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_tail
      assign rgt_data  = '0;
      assign rgt_valid = 1'b0;
    end else begin : g_mid
      assign rgt_data  = cell_data[i+1];
      assign rgt_valid = cell_valid[i+1];
    end

    sis_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_data   (lft_data),
      .left_valid  (lft_valid),
      .left_ins    (lft_ins),
      .right_data  (rgt_data),
      .right_valid (rgt_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .ins         (cell_ins[i])
    );
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && full) begin
          ovf_nxt = 1'b1;
        end
        if (in_acc && in_tlast) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (run_done) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // zero-extend the head value to the byte-padded bus
  assign out_tdata = TDATA_W'($unsigned(cell_data[0]));
  assign out_tuser = ovf_r;

  // ---- checks ----
  // draining always has a word in cell 0
  a_emit_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> cell_valid[0])
    else $error("drain with empty head cell");

  // occupied cells form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in cell chain");

  // the last input word starts the drain
  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == ST_EMIT))
    else $error("last word did not start drain");

  // a finished drain leaves the chain empty
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (cell_valid == '0) && !ovf_r)
    else $error("chain not empty after drain");

endmodule
